FILE: rtl/positional_array_list_engine_defines.svh
// assertion macros for the positional array list engine
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define PALE_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PALE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pale_pkg.sv
// types and codes shared by the positional array list engine
`timescale 1ns / 1ps

package pale_pkg;

   // command codes
   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_APPEND  = 3'd1,
      OP_DISPLAY = 3'd2,
      OP_INSERT  = 3'd3,
      OP_DELETE  = 3'd4,
      OP_SEARCH  = 3'd5
   } opcode_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_POS   = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_EMPTY     = 3'd3,
      STAT_FULL      = 3'd4,
      STAT_BAD_OP    = 3'd5
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISP_RD,
      ST_DISP_OUT,
      ST_INS_RD,
      ST_INS_WR,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_SRCH_RD,
      ST_SRCH_CMP
   } seq_state_type;

   // request payload
   typedef struct packed {
      opcode_type         opcode;
      logic [7:0]         position;
      logic signed [31:0] data_value;
   } req_type;

   // result payload
   typedef struct packed {
      status_type         status;
      logic signed [31:0] value_out;
      logic [6:0]         position_out;
      logic [6:0]         count_out;
      logic               last;
   } rsp_type;

   // one result from the sequencer
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } emit_type;

endpackage

FILE: rtl/pale_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pale_seq.sv
// command sequencer: walks the element ram with one shared index counter
`timescale 1ns / 1ps
`include "positional_array_list_engine_defines.svh"

module pale_seq #(
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  pale_pkg::req_type  req,
   output logic               busy,
   output pale_pkg::emit_type emit,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [31:0]        wr_data,
   output logic [AW-1:0]      rd_addr,
   input  logic [31:0]        rd_data
);

   localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
   localparam logic [CMPW-1:0] DEPTH_EXT = CMPW'(DEPTH);
   localparam logic [CMPW-1:0] ONE_EXT = CMPW'(1);

   pale_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    pos_ff, pos_in;
   logic [31:0]   key_ff, key_in;

   logic [CMPW-1:0] req_pos_ext, req_pos_m1, pos_ext, pos_m1, cnt_ext, idx_ext, idx_p1_ext;
   logic [CW-1:0]   idx_p1, idx_m1;
   logic            ins_bad, del_bad, list_full;

   // shared index arithmetic and position checks
   assign req_pos_ext = CMPW'(req.position);
   assign req_pos_m1  = req_pos_ext - ONE_EXT;
   assign pos_ext     = CMPW'(pos_ff);
   assign pos_m1      = pos_ext - ONE_EXT;
   assign cnt_ext     = CMPW'(count_ff);
   assign idx_ext     = CMPW'(idx_ff);
   assign idx_p1      = idx_ff + CW'(1);
   assign idx_m1      = idx_ff - CW'(1);
   assign idx_p1_ext  = CMPW'(idx_p1);
   assign list_full   = cnt_ext >= DEPTH_EXT;
   assign ins_bad     = (req.position == 8'd0) || (req_pos_ext > cnt_ext + ONE_EXT);
   assign del_bad     = (req.position == 8'd0) || (req_pos_ext > cnt_ext);

   assign busy = state_ff != pale_pkg::ST_IDLE;

   // state and list registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pale_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      key_ff <= key_in;
   end

   // next state, memory control and result generation
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_ff[AW-1:0];
      emit     = '0;
      emit.rsp.last = 1'b1;

      case (state_ff)
         pale_pkg::ST_IDLE: begin
            if (start) begin
               pos_in = req.position;
               key_in = req.data_value;
               case (req.opcode)
                  pale_pkg::OP_CLEAR: begin
                     count_in   = '0;
                     emit.valid = 1'b1;
                  end
                  pale_pkg::OP_APPEND: begin
                     emit.valid = 1'b1;
                     if (list_full) begin
                        emit.rsp.status = pale_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req.data_value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  pale_pkg::OP_DISPLAY: begin
                     if (count_ff == '0) begin
                        emit.valid      = 1'b1;
                        emit.rsp.status = pale_pkg::STAT_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = pale_pkg::ST_DISP_RD;
                     end
                  end
                  pale_pkg::OP_INSERT: begin
                     if (ins_bad) begin
                        emit.valid      = 1'b1;
                        emit.rsp.status = pale_pkg::STAT_BAD_POS;
                     end else if (list_full) begin
                        emit.valid      = 1'b1;
                        emit.rsp.status = pale_pkg::STAT_FULL;
                     end else begin
                        idx_in   = count_ff;
                        state_in = pale_pkg::ST_INS_RD;
                     end
                  end
                  pale_pkg::OP_DELETE: begin
                     if (del_bad) begin
                        emit.valid      = 1'b1;
                        emit.rsp.status = pale_pkg::STAT_BAD_POS;
                     end else begin
                        idx_in   = CW'(req_pos_m1);
                        state_in = pale_pkg::ST_DEL_RD;
                     end
                  end
                  pale_pkg::OP_SEARCH: begin
                     idx_in   = '0;
                     state_in = pale_pkg::ST_SRCH_RD;
                  end
                  default: begin
                     emit.valid      = 1'b1;
                     emit.rsp.status = pale_pkg::STAT_BAD_OP;
                  end
               endcase
            end
         end

         // display: read one element, then send it
         pale_pkg::ST_DISP_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = pale_pkg::ST_DISP_OUT;
         end
         pale_pkg::ST_DISP_OUT: begin
            emit.valid            = 1'b1;
            emit.rsp.value_out    = rd_data;
            emit.rsp.position_out = 7'(idx_p1);
            emit.rsp.last         = idx_p1 == count_ff;
            if (idx_p1 == count_ff) begin
               state_in = pale_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_p1;
               state_in = pale_pkg::ST_DISP_RD;
            end
         end

         // insert: move entries up from the end, then drop the value in
         pale_pkg::ST_INS_RD: begin
            if (idx_ext >= pos_ext) begin
               rd_addr  = idx_m1[AW-1:0];
               state_in = pale_pkg::ST_INS_WR;
            end else begin
               wr_en      = 1'b1;
               wr_addr    = AW'(pos_m1);
               wr_data    = key_ff;
               count_in   = count_ff + CW'(1);
               emit.valid = 1'b1;
               state_in   = pale_pkg::ST_IDLE;
            end
         end
         pale_pkg::ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_data  = rd_data;
            idx_in   = idx_m1;
            state_in = pale_pkg::ST_INS_RD;
         end

         // delete: move entries down over the removed slot
         pale_pkg::ST_DEL_RD: begin
            if (idx_p1_ext < cnt_ext) begin
               rd_addr  = idx_p1[AW-1:0];
               state_in = pale_pkg::ST_DEL_WR;
            end else begin
               count_in   = count_ff - CW'(1);
               emit.valid = 1'b1;
               state_in   = pale_pkg::ST_IDLE;
            end
         end
         pale_pkg::ST_DEL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_data  = rd_data;
            idx_in   = idx_p1;
            state_in = pale_pkg::ST_DEL_RD;
         end

         // search: read and compare one entry per pass
         pale_pkg::ST_SRCH_RD: begin
            if (idx_ext < cnt_ext) begin
               rd_addr  = idx_ff[AW-1:0];
               state_in = pale_pkg::ST_SRCH_CMP;
            end else begin
               emit.valid      = 1'b1;
               emit.rsp.status = pale_pkg::STAT_NOT_FOUND;
               state_in        = pale_pkg::ST_IDLE;
            end
         end
         pale_pkg::ST_SRCH_CMP: begin
            if (rd_data == key_ff) begin
               emit.valid            = 1'b1;
               emit.rsp.position_out = 7'(idx_p1);
               state_in              = pale_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_p1;
               state_in = pale_pkg::ST_SRCH_RD;
            end
         end

         default: begin
            state_in = pale_pkg::ST_IDLE;
         end
      endcase

      emit.rsp.count_out = 7'(count_in);
   end

   // sequencer checks
   `PALE_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count above depth")
   `PALE_ASSERT_HOLDS(a_write_in_list, clock, reset, wr_en, CW'(wr_addr) <= count_ff, "write past list end")
   `PALE_ASSERT_NEXT(a_last_ends_cmd, clock, reset, emit.valid && emit.rsp.last, state_ff == pale_pkg::ST_IDLE, "busy after final result")
   `PALE_ASSERT_NEXT(a_more_follows, clock, reset, emit.valid && !emit.rsp.last, state_ff == pale_pkg::ST_DISP_RD, "display walk stopped early")

endmodule

FILE: rtl/positional_array_list_engine.sv
// top level of the positional array list engine
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values held in one element ram
// with a registered read port. A request is taken when start is high and
// busy is low. Clear, append, an invalid opcode and any rejected command
// (bad position, full list, display of an empty list) finish at once: the
// result appears on the cycle after the request and busy stays low.
// Every walk over the list goes through a single index counter and the one
// ram read port: display reads and sends each entry, insert and delete
// read and write each entry they move, search reads and compares entries
// in turn, and insert ends by writing the new value. Each result is
// registered and shown for exactly one cycle with rsp_strobe high; the
// receiver cannot stall, so it must take every result as it comes. Display
// gives one result per element, last set on the final one.

module positional_array_list_engine #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pale_pkg::req_type req_data,
   output logic              rsp_strobe,
   output pale_pkg::rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pale_pkg::emit_type emit;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [31:0]        wr_data, rd_data;
   logic               rsp_strobe_ff;
   pale_pkg::rsp_type  rsp_data_ff;

   // command sequencer
   pale_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req_data),
      .busy    (busy),
      .emit    (emit),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // element store
   pale_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit.valid;
      end
      rsp_data_ff <= emit.rsp;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the positional array list engine
`timescale 1ns / 1ps

module testbench;
   import pale_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS = 10;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   // list as the block should hold it, and results still owed by the block
   logic signed [31:0] list_mem [0:LIST_DEPTH-1];
   int unsigned list_len = 0;
   rsp_type expected_q [$];

   int fail_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int full_count = 0;
   int display_count = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;

   positional_array_list_engine #(.DEPTH(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_type make_rsp(status_type st, logic signed [31:0] v,
                                        int unsigned p, logic fin);
      rsp_type r;
      r.status = st;
      r.value_out = v;
      r.position_out = p[6:0];
      r.count_out = list_len[6:0];
      r.last = fin;
      return r;
   endfunction

   // update the list for one request and queue the results it owes
   function automatic void apply_list_command(req_type r);
      int unsigned pos;
      int unsigned k;
      bit hit;
      pos = r.position;
      hit = 1'b0;
      case (r.opcode)
         OP_CLEAR: begin
            list_len = 0;
            expected_q.push_back(make_rsp(STAT_OK, 0, 0, 1'b1));
         end
         OP_APPEND: begin
            if (list_len >= LIST_DEPTH) begin
               full_count++;
               expected_q.push_back(make_rsp(STAT_FULL, 0, 0, 1'b1));
            end else begin
               list_mem[list_len] = r.data_value;
               list_len++;
               expected_q.push_back(make_rsp(STAT_OK, 0, 0, 1'b1));
            end
         end
         OP_DISPLAY: begin
            display_count++;
            if (list_len == 0)
               expected_q.push_back(make_rsp(STAT_EMPTY, 0, 0, 1'b1));
            else
               for (k = 0; k < list_len; k++)
                  expected_q.push_back(make_rsp(STAT_OK, list_mem[k], k + 1,
                                                k + 1 == list_len));
         end
         OP_INSERT: begin
            if (pos < 1 || pos > list_len + 1) begin
               expected_q.push_back(make_rsp(STAT_BAD_POS, 0, 0, 1'b1));
            end else if (list_len >= LIST_DEPTH) begin
               full_count++;
               expected_q.push_back(make_rsp(STAT_FULL, 0, 0, 1'b1));
            end else begin
               for (k = list_len; k >= pos; k--)
                  list_mem[k] = list_mem[k-1];
               list_mem[pos-1] = r.data_value;
               list_len++;
               expected_q.push_back(make_rsp(STAT_OK, 0, 0, 1'b1));
            end
         end
         OP_DELETE: begin
            if (pos < 1 || pos > list_len) begin
               expected_q.push_back(make_rsp(STAT_BAD_POS, 0, 0, 1'b1));
            end else begin
               for (k = pos - 1; k + 1 < list_len; k++)
                  list_mem[k] = list_mem[k+1];
               list_len--;
               expected_q.push_back(make_rsp(STAT_OK, 0, 0, 1'b1));
            end
         end
         OP_SEARCH: begin
            for (k = 0; k < list_len && !hit; k++)
               if (list_mem[k] == r.data_value) begin
                  hit = 1'b1;
                  expected_q.push_back(make_rsp(STAT_OK, 0, k + 1, 1'b1));
               end
            if (!hit)
               expected_q.push_back(make_rsp(STAT_NOT_FOUND, 0, 0, 1'b1));
         end
         default: begin
            expected_q.push_back(make_rsp(STAT_BAD_OP, 0, 0, 1'b1));
         end
      endcase
   endfunction

   // compare one result against the oldest one owed
   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("ERROR: unexpected result status=%0d value=%0d pos=%0d count=%0d last=%0b",
                     got.status, got.value_out, got.position_out, got.count_out, got.last);
         return;
      end
      want = expected_q.pop_front();
      checked_count++;
      if (got.status !== want.status || got.value_out !== want.value_out ||
          got.position_out !== want.position_out || got.count_out !== want.count_out ||
          got.last !== want.last) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("ERROR: result mismatch at %0t", $realtime);
            $display("   expected status=%0d value=%0d pos=%0d count=%0d last=%0b",
                     want.status, want.value_out, want.position_out, want.count_out,
                     want.last);
            $display("   actual   status=%0d value=%0d pos=%0d count=%0d last=%0b",
                     got.status, got.value_out, got.position_out, got.count_out, got.last);
         end
      end
   endfunction

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         check_result(rsp_data);
   end

   // watchdog on cycles with no request or result taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: watchdog expired, %0d results still owed", expected_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic req_type make_req(opcode_type op, int unsigned pos,
                                        logic signed [31:0] d);
      req_type r;
      r.opcode = op;
      r.position = pos[7:0];
      r.data_value = d;
      return r;
   endfunction

   // random request, mostly well formed against the current list
   function automatic req_type random_request();
      int unsigned roll;
      opcode_type op;
      int unsigned pos;
      logic signed [31:0] d;
      roll = $urandom_range(0, 99);
      if (roll < 25) op = OP_APPEND;
      else if (roll < 45) op = OP_INSERT;
      else if (roll < 65) op = OP_DELETE;
      else if (roll < 82) op = OP_SEARCH;
      else if (roll < 89) op = OP_DISPLAY;
      else if (roll < 92) op = OP_CLEAR;
      else if (roll < 96) op = opcode_type'(OP_RSVD_6);
      else op = opcode_type'(OP_RSVD_7);
      // keep the list from sitting at full
      if (list_len > 40 && (op == OP_APPEND || op == OP_INSERT) && $urandom_range(0, 1))
         op = OP_DELETE;
      if ($urandom_range(0, 4) == 0)
         pos = $urandom_range(0, 255);
      else if (op == OP_DELETE)
         pos = (list_len == 0) ? 1 : $urandom_range(1, list_len);
      else
         pos = $urandom_range(1, list_len + 1);
      if (list_len > 0 && $urandom_range(0, 9) < 3)
         d = list_mem[$urandom_range(0, list_len - 1)];
      else
         d = $urandom;
      return make_req(op, pos, d);
   endfunction

   // drive one request and hold it until taken
   task automatic send_request(input req_type item);
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      apply_list_command(item);
      sent_count++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // hold off until every owed result is in
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // boundary values, every opcode, bad positions and an empty display
   task automatic test_directed();
      send_request(make_req(OP_DISPLAY, 0, 0));
      send_request(make_req(OP_DELETE, 1, 0));
      send_request(make_req(OP_SEARCH, 0, 32'sd0));
      send_request(make_req(OP_INSERT, 0, 32'sd5));
      send_request(make_req(OP_INSERT, 1, 32'sh7FFFFFFF));
      send_request(make_req(OP_APPEND, 0, 32'sh80000000));
      send_request(make_req(OP_APPEND, 255, 32'sd0));
      send_request(make_req(OP_APPEND, 0, -32'sd1));
      send_request(make_req(OP_INSERT, 5, 32'sd1234));
      send_request(make_req(OP_INSERT, 7, 32'sd99));
      send_request(make_req(OP_INSERT, 255, 32'sd99));
      send_request(make_req(OP_INSERT, 3, 32'shA5A5A5A5));
      send_request(make_req(OP_DISPLAY, 0, 0));
      send_request(make_req(OP_SEARCH, 0, 32'sd0));
      send_request(make_req(OP_SEARCH, 0, 32'sh5A5A5A5A));
      send_request(make_req(OP_APPEND, 0, 32'sd0));
      send_request(make_req(OP_SEARCH, 170, 32'sd0));
      send_request(make_req(OP_DELETE, 0, 0));
      send_request(make_req(OP_DELETE, 8, 0));
      send_request(make_req(OP_DELETE, 7, 0));
      send_request(make_req(OP_DELETE, 1, 0));
      send_request(make_req(opcode_type'(OP_RSVD_6), 85, $urandom));
      send_request(make_req(opcode_type'(OP_RSVD_7), 255, -32'sd1));
      send_request(make_req(OP_CLEAR, 0, 0));
      send_request(make_req(OP_DISPLAY, 0, 0));
   endtask

   // fill to DEPTH, hit the full checks, then the longest shifts
   task automatic test_full_list();
      int i;
      send_request(make_req(OP_CLEAR, 0, 0));
      for (i = 0; i < LIST_DEPTH; i++)
         send_request(make_req(OP_APPEND, 0, $urandom));
      send_request(make_req(OP_APPEND, 0, $urandom));
      send_request(make_req(OP_INSERT, LIST_DEPTH + 1, $urandom));
      send_request(make_req(OP_INSERT, LIST_DEPTH + 2, $urandom));
      send_request(make_req(OP_INSERT, 1, $urandom));
      send_request(make_req(OP_DISPLAY, 0, 0));
      send_request(make_req(OP_SEARCH, 0, list_mem[LIST_DEPTH-1]));
      send_request(make_req(OP_DELETE, LIST_DEPTH, 0));
      send_request(make_req(OP_DELETE, 1, 0));
      send_request(make_req(OP_INSERT, 1, $urandom));
      send_request(make_req(OP_INSERT, 1, list_mem[5]));
      send_request(make_req(OP_SEARCH, 0, list_mem[0]));
      send_request(make_req(OP_DISPLAY, 0, 0));
   endtask

   // random mix with idle bursts
   task automatic test_random_mix(input int n);
      int i;
      for (i = 0; i < n; i++)
         send_request(random_request());
   endtask

   // random mix with the request side never idle
   task automatic test_back_to_back(input int n);
      int i;
      gaps_on = 1'b0;
      for (i = 0; i < n; i++)
         send_request(random_request());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_full_list();
      test_random_mix(140);
      wait_drained();
      test_back_to_back(40);
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_q.size() != 0)
         fail_count++;
      $display("summary: %0d requests, %0d results checked, %0d displays, %0d full rejects",
               sent_count, checked_count, display_count, full_count);
      $display("summary: list filled to %0d and walked with idle bursts and back to back",
               LIST_DEPTH);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/pale_pkg.sv
rtl/pale_ram.sv
rtl/pale_seq.sv
rtl/positional_array_list_engine.sv
tb/testbench.sv
